// ----- rtl/pixel_to_bearing_angle_core_defines.svh -----
// assertion macros for the pixel to bearing angle core
// used by files that assert; needs a clock named aclk and reset aresetn
`ifndef PIXEL_TO_BEARING_ANGLE_CORE_DEFINES_SVH
`define PIXEL_TO_BEARING_ANGLE_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define P2BA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define P2BA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/p2ba_pkg.sv -----
// shared types, constants and arctangent step table for the bearing core
// no dependencies
`timescale 1ns / 1ps

package p2ba_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STEPS    = 24;
    localparam int ZW  = ANGLE_FRAC_BITS + 9;
    localparam int RW  = 33;
    localparam int VW  = 48;
    localparam int MW  = ANGLE_FRAC_BITS + 15;
    localparam int LANE_LAT = 2 * CORDIC_STEPS + 3;

    localparam logic [12:0] SIZE_MIN = 13'd100;
    localparam logic [12:0] SIZE_MAX = 13'd8000;
    localparam logic [7:0]  FOV_MIN  = 8'd10;
    localparam logic [7:0]  FOV_MAX  = 8'd150;
    localparam logic [12:0] ANGLE_SAT = 13'd7500;

    localparam longint ATAN_Q24 [CORDIC_STEPS] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_FOV_H        = 3'd2,
        REG_FOV_V        = 3'd3,
        REG_OFFSET_X     = 3'd4,
        REG_OFFSET_Y     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic en;
    } lane_ctrl_t;

    function automatic logic signed [ZW-1:0] step_angle(input int i);
        longint t;
        t = ATAN_Q24[i];
        return ZW'((((t <<< 1) >>> (24 - ANGLE_FRAC_BITS)) + 1) >>> 1);
    endfunction

endpackage

// ----- rtl/p2ba_lane.sv -----
// one axis lane: clamps, cordic rotation for the fov, scaling, cordic vectoring, rounding
// depends on p2ba_pkg
`timescale 1ns / 1ps

module p2ba_lane
    import p2ba_pkg::*;
(
    input  logic                aclk,
    input  lane_ctrl_t          ctrl,
    input  logic                negate,
    input  logic [12:0]         size,
    input  logic [7:0]          fov,
    input  logic signed [18:0]  centre,
    output logic signed [13:0]  angle
);

    logic [12:0]        p_clamp;
    logic [7:0]         f_clamp;
    logic [12:0]        c_clamp;

    logic [12:0]        rp_reg [0:CORDIC_STEPS];
    logic signed [14:0] rd_reg [0:CORDIC_STEPS];
    logic signed [RW-1:0] rx_reg [0:CORDIC_STEPS];
    logic signed [RW-1:0] ry_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] rz_reg [0:CORDIC_STEPS];

    logic signed [VW-1:0] vx_reg [0:CORDIC_STEPS];
    logic signed [VW-1:0] vy_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] vz_reg [0:CORDIC_STEPS];

    logic signed [ZW-1:0] z_fin;
    logic [ZW-1:0]        mag;
    logic [MW-1:0]        scaled;
    logic [12:0]          r_sat;
    logic                 neg;
    logic signed [13:0]   angle_next;
    logic signed [13:0]   angle_reg;

    always_comb begin
        if (size < SIZE_MIN) p_clamp = SIZE_MIN;
        else if (size > SIZE_MAX) p_clamp = SIZE_MAX;
        else p_clamp = size;
        if (fov < FOV_MIN) f_clamp = FOV_MIN;
        else if (fov > FOV_MAX) f_clamp = FOV_MAX;
        else f_clamp = fov;
        if (centre < 0) c_clamp = '0;
        else if (centre > signed'(19'(p_clamp))) c_clamp = p_clamp;
        else c_clamp = centre[12:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            rp_reg[0] <= p_clamp;
            rd_reg[0] <= signed'({1'b0, c_clamp, 1'b0}) - signed'(15'(p_clamp));
            rx_reg[0] <= RW'(1) <<< 30;
            ry_reg[0] <= '0;
            rz_reg[0] <= signed'(ZW'(f_clamp)) <<< (ANGLE_FRAC_BITS - 1);
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        localparam logic signed [ZW-1:0] A = step_angle(k);
        always_ff @(posedge aclk) begin
            if (ctrl.en) begin
                rp_reg[k+1] <= rp_reg[k];
                rd_reg[k+1] <= rd_reg[k];
                if (!rz_reg[k][ZW-1]) begin
                    rx_reg[k+1] <= rx_reg[k] - (ry_reg[k] >>> k);
                    ry_reg[k+1] <= ry_reg[k] + (rx_reg[k] >>> k);
                    rz_reg[k+1] <= rz_reg[k] - A;
                end else begin
                    rx_reg[k+1] <= rx_reg[k] + (ry_reg[k] >>> k);
                    ry_reg[k+1] <= ry_reg[k] - (rx_reg[k] >>> k);
                    rz_reg[k+1] <= rz_reg[k] + A;
                end
            end
        end
    end

    // scale the rotated unit vector by frame size and centre distance
    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            vx_reg[0] <= VW'(signed'({1'b0, rp_reg[CORDIC_STEPS]}))
                         * VW'(rx_reg[CORDIC_STEPS]);
            vy_reg[0] <= VW'(rd_reg[CORDIC_STEPS]) * VW'(ry_reg[CORDIC_STEPS]);
            vz_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
        localparam logic signed [ZW-1:0] A = step_angle(k);
        always_ff @(posedge aclk) begin
            if (ctrl.en) begin
                if (!vy_reg[k][VW-1]) begin
                    vx_reg[k+1] <= vx_reg[k] + (vy_reg[k] >>> k);
                    vy_reg[k+1] <= vy_reg[k] - (vx_reg[k] >>> k);
                    vz_reg[k+1] <= vz_reg[k] + A;
                end else begin
                    vx_reg[k+1] <= vx_reg[k] - (vy_reg[k] >>> k);
                    vy_reg[k+1] <= vy_reg[k] + (vx_reg[k] >>> k);
                    vz_reg[k+1] <= vz_reg[k] - A;
                end
            end
        end
    end

    // hundredths of a degree, halves away from zero, saturated
    always_comb begin
        z_fin  = vz_reg[CORDIC_STEPS];
        neg    = z_fin[ZW-1];
        mag    = neg ? ZW'(-z_fin) : ZW'(z_fin);
        scaled = MW'(mag) * MW'(100) + (MW'(1) << (ANGLE_FRAC_BITS - 1));
        if ((scaled >> ANGLE_FRAC_BITS) > MW'(ANGLE_SAT)) r_sat = ANGLE_SAT;
        else r_sat = 13'(scaled >> ANGLE_FRAC_BITS);
        angle_next = (neg ^ negate) ? -signed'({1'b0, r_sat}) : signed'({1'b0, r_sat});
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

// ----- rtl/pixel_to_bearing_angle_core.sv -----
// throughput: one report per cycle while m_ is not stalled; two axis lanes of 24+24 cordic stages run in step
// backpressure on m_ stalls the whole pipeline; s_tready follows it
// reports with status other than 1 are taken but give no result
// reset (aresetn low, synchronous) clears valid flags and loads default registers
`timescale 1ns / 1ps

module pixel_to_bearing_angle_core
    import p2ba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // box_left, box_width, box_top, box_height
    input  logic [7:0]  s_tuser,  // report_status
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // bearing_horizontal, bearing_vertical, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data
);

`include "pixel_to_bearing_angle_core_defines.svh"

    logic [12:0]        frame_width_reg;
    logic [12:0]        frame_height_reg;
    logic [7:0]         fov_h_reg;
    logic [7:0]         fov_v_reg;
    logic signed [13:0] offset_x_reg;
    logic signed [13:0] offset_y_reg;

    logic [LANE_LAT-1:0] valid_reg;
    lane_ctrl_t          ctrl;
    logic signed [18:0]  cx;
    logic signed [18:0]  cy;
    logic signed [13:0]  ang_h;
    logic signed [13:0]  ang_v;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 13'd1920;
            frame_height_reg <= 13'd1080;
            fov_h_reg        <= 8'd54;
            fov_v_reg        <= 8'd40;
            offset_x_reg     <= '0;
            offset_y_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[12:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[12:0];
                REG_FOV_H:        fov_h_reg        <= cfg_data[7:0];
                REG_FOV_V:        fov_v_reg        <= cfg_data[7:0];
                REG_OFFSET_X:     offset_x_reg     <= signed'(cfg_data);
                REG_OFFSET_Y:     offset_y_reg     <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    assign ctrl.en  = !m_tvalid || m_tready;
    assign s_tready = ctrl.en;

    always_comb begin
        cx = signed'(19'(s_tdata[15:0])) + signed'(19'(s_tdata[31:17]))
             - 19'(offset_x_reg);
        cy = signed'(19'(s_tdata[47:32])) + signed'(19'(s_tdata[63:49]))
             - 19'(offset_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.en) begin
            valid_reg <= {valid_reg[LANE_LAT-2:0], s_tvalid && (s_tuser == 8'd1)};
        end
    end

    p2ba_lane u_lane_h (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .negate (1'b0),
        .size   (frame_width_reg),
        .fov    (fov_h_reg),
        .centre (cx),
        .angle  (ang_h)
    );

    p2ba_lane u_lane_v (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .negate (1'b1),
        .size   (frame_height_reg),
        .fov    (fov_v_reg),
        .centre (cy),
        .angle  (ang_v)
    );

    assign m_tvalid = valid_reg[LANE_LAT-1];
    assign m_tdata  = {4'b0, ang_v, ang_h};

    `P2BA_ASSERT(a_h_range, !m_tvalid || (ang_h <= 14'sd7500 && ang_h >= -14'sd7500), "horizontal bearing out of range")
    `P2BA_ASSERT(a_v_range, !m_tvalid || (ang_v <= 14'sd7500 && ang_v >= -14'sd7500), "vertical bearing out of range")
    `P2BA_ASSERT(a_ready, s_tready == (!m_tvalid || m_tready), "input ready not tied to output stall")
    `P2BA_ASSERT_NEXT(a_cfg_fw, cfg_valid && cfg_index == REG_FRAME_WIDTH, frame_width_reg == $past(cfg_data[12:0]), "frame width write lost")

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for pixel_to_bearing_angle_core: box reports in, bearings out
// predicts both cordic axes in fixed point, compares every result; needs p2ba_pkg
`timescale 1ns / 1ps

module tb_top;
    import p2ba_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct {
        logic [7:0]  status;
        logic [15:0] left;
        logic [15:0] wid;
        logic [15:0] top;
        logic [15:0] hgt;
    } box_report_t;

    typedef struct {
        logic signed [13:0] horiz;
        logic signed [13:0] vert;
    } bearing_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // box_left, box_width, box_top, box_height
    logic [7:0]  s_tuser;   // report_status
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // bearing_horizontal, bearing_vertical, zero pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [13:0] cfg_data;

    box_report_t pending_reports[$];
    bearing_t    bearing_q[$];

    logic [12:0]        frame_w, frame_h;
    logic [7:0]         fov_h, fov_v;
    logic signed [13:0] off_x, off_y;

    int  errors = 0;
    int  reports_added = 0;
    int  reports_sent = 0;
    int  bearings_seen = 0;
    int  cfg_writes = 0;
    int  cycles = 0;
    bit  no_idle = 0;

    pixel_to_bearing_angle_core DUT (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic longint clamp_l(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint atan_step(int i);
        longint t;
        t = ATAN_Q24[i];
        return (((t <<< 1) >>> (24 - ANGLE_FRAC_BITS)) + 1) >>> 1;
    endfunction

    function automatic longint axis_bearing(longint size_reg, longint fov_reg, longint centre);
        longint p, f, c, x, y, z, nx, vx, vy, mag, r;
        p = clamp_l(size_reg, 100, 8000);
        f = clamp_l(fov_reg, 10, 150);
        c = clamp_l(centre, 0, p);
        x = 64'sd1 <<< 30;
        y = 0;
        z = f <<< (ANGLE_FRAC_BITS - 1);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_step(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_step(i);
            end
            x = nx;
        end
        vx = p * x;
        vy = (2 * c - p) * y;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (vy >= 0) begin
                nx = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                z  = z + atan_step(i);
            end else begin
                nx = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                z  = z - atan_step(i);
            end
            vx = nx;
        end
        mag = (z < 0) ? -z : z;
        r = (mag * 100 + (64'sd1 <<< (ANGLE_FRAC_BITS - 1))) >>> ANGLE_FRAC_BITS;
        if (r > 7500) r = 7500;
        return (z < 0) ? -r : r;
    endfunction

    function automatic void predict_bearing(box_report_t rep);
        bearing_t b;
        longint cx, cy;
        if (rep.status != 8'd1) return;
        cx = longint'(rep.left) + longint'(rep.wid >> 1) - longint'(off_x);
        cy = longint'(rep.top) + longint'(rep.hgt >> 1) - longint'(off_y);
        b.horiz = 14'(axis_bearing(longint'(frame_w), longint'(fov_h), cx));
        b.vert  = 14'(-axis_bearing(longint'(frame_h), longint'(fov_v), cy));
        bearing_q.push_back(b);
    endfunction

    // driver
    box_report_t cur_rep;
    int          send_gap = 0;
    always @(posedge aclk) begin
        logic busy;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_bearing(cur_rep);
                reports_sent++;
                busy = 1'b0;
            end else begin
                busy = s_tvalid;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reports.size() > 0) begin
                    cur_rep = pending_reports.pop_front();
                    s_tdata <= {cur_rep.hgt, cur_rep.top, cur_rep.wid, cur_rep.left};
                    s_tuser <= cur_rep.status;
                    busy = 1'b1;
                    send_gap = no_idle ? 0 : $urandom_range(0, 11);
                end
            end
            s_tvalid <= busy;
        end
    end

    // monitor with one long hold-off to back up the pipeline
    int stall = 0;
    bit held = 0;
    always @(posedge aclk) begin
        bearing_t want;
        logic signed [13:0] got_h, got_v;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_h = m_tdata[13:0];
                got_v = m_tdata[27:14];
                bearings_seen++;
                if (bearing_q.size() == 0) begin
                    $display("%0t: unexpected transaction h=%0d v=%0d", $time, got_h, got_v);
                    errors++;
                end else begin
                    want = bearing_q.pop_front();
                    if (got_h !== want.horiz) begin
                        $display("%0t: horizontal expected %0d actual %0d",
                                 $time, want.horiz, got_h);
                        errors++;
                    end
                    if (got_v !== want.vert) begin
                        $display("%0t: vertical expected %0d actual %0d",
                                 $time, want.vert, got_v);
                        errors++;
                    end
                    if (m_tdata[31:28] !== 4'd0) begin
                        $display("%0t: pad expected 0 actual %0h", $time, m_tdata[31:28]);
                        errors++;
                    end
                end
                stall = no_idle ? 0 : $urandom_range(0, 11);
            end
            if (!held && reports_sent >= 300) begin
                held = 1;
                stall = 400;
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [13:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_FRAME_WIDTH:  frame_w = val[12:0];
            REG_FRAME_HEIGHT: frame_h = val[12:0];
            REG_FOV_H:        fov_h = val[7:0];
            REG_FOV_V:        fov_v = val[7:0];
            REG_OFFSET_X:     off_x = val;
            REG_OFFSET_Y:     off_y = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (reports_sent < reports_added || bearing_q.size() > 0);
        repeat (LANE_LAT + 10) @(posedge aclk);
    endtask

    task automatic add_report(logic [7:0] st, logic [15:0] l, logic [15:0] w,
                              logic [15:0] t, logic [15:0] h);
        box_report_t r;
        r.status = st;
        r.left = l;
        r.wid = w;
        r.top = t;
        r.hgt = h;
        pending_reports.push_back(r);
        reports_added++;
    endtask

    task automatic add_random(int n, int span);
        logic [7:0] st;
        for (int i = 0; i < n; i++) begin
            st = ($urandom_range(0, 9) < 8) ? 8'd1 : 8'($urandom);
            if ($urandom_range(0, 3) == 0)
                add_report(st, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
                add_report(st, 16'($urandom_range(0, span)), 16'($urandom_range(0, span / 2)),
                           16'($urandom_range(0, span)), 16'($urandom_range(0, span / 2)));
        end
    endtask

    task automatic write_all(logic [12:0] w, logic [12:0] h, logic [7:0] fh,
                             logic [7:0] fv, logic [13:0] ox, logic [13:0] oy);
        write_reg(REG_FRAME_WIDTH, {1'b0, w});
        write_reg(REG_FRAME_HEIGHT, {1'b0, h});
        write_reg(REG_FOV_H, {6'd0, fh});
        write_reg(REG_FOV_V, {6'd0, fv});
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        frame_w = 13'd1920;
        frame_h = 13'd1080;
        fov_h = 8'd54;
        fov_v = 8'd40;
        off_x = '0;
        off_y = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, default registers
        add_report(8'd0, 16'd960, 16'd0, 16'd540, 16'd0);
        add_report(8'd2, 16'd100, 16'd10, 16'd100, 16'd10);
        add_report(8'd255, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_report(8'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        add_report(8'd1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_report(8'd1, 16'd960, 16'd0, 16'd540, 16'd0);
        add_report(8'd1, 16'd959, 16'd3, 16'd539, 16'd3);
        add_report(8'd1, 16'd1920, 16'd0, 16'd1080, 16'd0);
        add_report(8'd1, 16'd1919, 16'd1, 16'd1079, 16'd1);
        add_report(8'd1, 16'd0, 16'd1, 16'd0, 16'd1);
        add_report(8'd1, 16'd0, 16'hfffe, 16'd0, 16'hfffe);
        add_report(8'd1, 16'd1000, 16'd0, 16'd0, 16'd2000);
        add_report(8'd1, 16'd5, 16'd7, 16'd1000, 16'd300);
        add_report(8'd1, 16'h8000, 16'd0, 16'h8000, 16'd0);
        add_report(8'd1, 16'd1500, 16'd100, 16'd200, 16'd50);
        add_report(8'd3, 16'd1500, 16'd100, 16'd200, 16'd50);
        add_random(140, 2200);
        wait_drained();

        // lowest register values, ignored indexes too
        write_all(13'd0, 13'd0, 8'd0, 8'd0, 14'h2000, 14'h2000);
        write_reg(3'd6, 14'h3fff);
        write_reg(3'd7, 14'h1555);
        no_idle = 1;
        add_report(8'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        add_random(220, 300);
        wait_drained();

        // highest register values
        write_all(13'h1fff, 13'h1fff, 8'hff, 8'hff, 14'h1fff, 14'h1fff);
        no_idle = 0;
        add_report(8'd1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_random(240, 20000);
        wait_drained();

        // clamp boundaries
        write_all(13'd8000, 13'd100, 8'd150, 8'd10, 14'h3ffe, 14'd3);
        add_random(230, 9000);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            write_all(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 180)),
                      14'($urandom), 14'($urandom));
            no_idle = (ph == 1);
            add_random(240, 8500);
            wait_drained();
        end

        $display("covered %0d reports, %0d bearings checked, %0d register writes",
                 reports_sent, bearings_seen, cfg_writes);
        $display("register sets included range extremes, clamp edges and random values");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- pixel_to_bearing_angle_core.f -----
+incdir+rtl
rtl/p2ba_pkg.sv
rtl/p2ba_lane.sv
rtl/pixel_to_bearing_angle_core.sv
bench/tb_top.sv
